// ===== rtl/isolated_mismatch_caller_macros.svh =====
// Assertion macros used by the isolated mismatch caller RTL.
`ifndef ISOLATED_MISMATCH_CALLER_MACROS_SVH
`define ISOLATED_MISMATCH_CALLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imc assertion failed");

// Next-cycle implication, disabled during reset.
`define IMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imc assertion failed");

`endif

// ===== rtl/imc_pkg.sv =====
// Package: constants, controller states and base complement for the mismatch caller.
`timescale 1ns / 1ps
package imc_pkg;

   localparam int MAX_LEN    = 128;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int RESULT_CAP = 64;
   localparam int CAP_W      = $clog2(RESULT_CAP + 1);
   localparam int BASE_W     = 8;
   localparam int STRAND_W   = 2;
   localparam int POS_W      = 7;

   localparam logic [STRAND_W-1:0] STRAND_FWD = 2'd0;
   localparam logic [STRAND_W-1:0] STRAND_REV = 2'd1;

   localparam logic [BASE_W-1:0] BASE_A = 8'h41;
   localparam logic [BASE_W-1:0] BASE_C = 8'h43;
   localparam logic [BASE_W-1:0] BASE_G = 8'h47;
   localparam logic [BASE_W-1:0] BASE_T = 8'h54;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CHK_RD,
      ST_CHK_EV,
      ST_EM_RD,
      ST_EM_EV,
      ST_EM_OUT
   } state_type;

   // Watson-Crick complement; other bytes pass unchanged
   function automatic logic [BASE_W-1:0] complement_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      r = b;
      if (b == BASE_A) r = BASE_T;
      else if (b == BASE_T) r = BASE_A;
      else if (b == BASE_C) r = BASE_G;
      else if (b == BASE_G) r = BASE_C;
      return r;
   endfunction

endpackage

// ===== rtl/imc_req_if.sv =====
// Request channel interface: one tumour/healthy base pair per request.
`timescale 1ns / 1ps
interface imc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] tumour_base;
   logic [7:0] germline_base;
   logic [1:0] strand;
   logic       last_base;

   modport source (output valid, tumour_base, germline_base, strand, last_base,
                   input ready);
   modport sink   (input valid, tumour_base, germline_base, strand, last_base,
                   output ready);
endinterface

// ===== rtl/imc_rsp_if.sv =====
// Response channel interface: one isolated mismatch per response.
`timescale 1ns / 1ps
interface imc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] snv_position;
   logic [7:0] normal_base;
   logic [7:0] mutant_base;
   logic       last_snv;

   modport source (output valid, snv_position, normal_base, mutant_base, last_snv,
                   input ready);
   modport sink   (input valid, snv_position, normal_base, mutant_base, last_snv,
                   output ready);
endinterface

// ===== rtl/imc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module imc_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/isolated_mismatch_caller.sv =====
// Isolated mismatch caller top level: sequence memories and scan controller.
`timescale 1ns / 1ps
`include "isolated_mismatch_caller_macros.svh"
// Loads one tumour/healthy base pair per cycle into two 128-entry memories
// (strand taken from the first request), then on the last pair scans the stored
// sequence: a check pass looking for adjacent mismatches (indel signature,
// nothing reported) and counting mismatches, then, if it found some and none
// adjacent, an emit pass that returns each isolated mismatch in ascending
// position, at most 64, with last_snv on the final one. Sequences shorter than
// two pairs or of another strand are dropped. Each position is read and then
// compared, as each memory has one read port with a registered read; a response
// waits on rsp_chan.ready. Requests are not taken during the scan. The memories
// need no clearing pass: only entries written for the current sequence are read.
module isolated_mismatch_caller (
   input logic       clock,
   input logic       reset,
   imc_req_if.sink   req_chan,
   imc_rsp_if.source rsp_chan
);
   import imc_pkg::*;

   state_type            state_ff, state_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [STRAND_W-1:0]  strand_ff, strand_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic                 prev_mm_ff, prev_mm_in;
   logic [LEN_W-1:0]     mm_count_ff, mm_count_in;
   logic [CAP_W-1:0]     limit_ff, limit_in;
   logic [CAP_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [BASE_W-1:0]    normal_ff, normal_in;
   logic [BASE_W-1:0]    mutant_ff, mutant_in;
   logic                 last_ff, last_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ADDR_W-1:0]    t_rd_addr;
   logic [BASE_W-1:0]    t_rd_data;
   logic [BASE_W-1:0]    h_rd_data;
   logic                 is_rev;
   logic [BASE_W-1:0]    mutant_now;
   logic                 mm_now;
   logic                 at_end;
   logic [LEN_W-1:0]     len_new;
   logic [LEN_W-1:0]     mm_count_new;
   logic                 last_taken;

   // Sequence memories
   imc_ram #(.DATA_W(BASE_W), .DEPTH(MAX_LEN)) u_tumour_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.tumour_base),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   imc_ram #(.DATA_W(BASE_W), .DEPTH(MAX_LEN)) u_healthy_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.germline_base),
      .rd_addr (idx_ff),
      .rd_data (h_rd_data)
   );

   // Store addressing and reverse-strand read address
   assign req_chan.ready = (state_ff == ST_LOAD);
   assign wr_en     = req_chan.valid && req_chan.ready && (len_ff < LEN_W'(MAX_LEN));
   assign wr_addr   = len_ff[ADDR_W-1:0];
   assign is_rev    = (strand_ff == STRAND_REV);
   assign t_rd_addr = is_rev ? ADDR_W'(len_ff - LEN_W'(1) - LEN_W'(idx_ff)) : idx_ff;

   // Compare of the pair read in the previous cycle
   assign mutant_now = is_rev ? complement_base(t_rd_data) : t_rd_data;
   assign mm_now     = (mutant_now != h_rd_data);
   assign at_end     = (idx_ff == ADDR_W'(len_ff - LEN_W'(1)));

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         strand_ff    <= STRAND_FWD;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         strand_ff    <= strand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan counters and response payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      prev_mm_ff  <= prev_mm_in;
      mm_count_ff <= mm_count_in;
      limit_ff    <= limit_in;
      emit_cnt_ff <= emit_cnt_in;
      pos_ff      <= pos_in;
      normal_ff   <= normal_in;
      mutant_ff   <= mutant_in;
      last_ff     <= last_in;
   end

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      strand_in    = strand_ff;
      idx_in       = idx_ff;
      prev_mm_in   = prev_mm_ff;
      mm_count_in  = mm_count_ff;
      limit_in     = limit_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_in       = pos_ff;
      normal_in    = normal_ff;
      mutant_in    = mutant_ff;
      last_in      = last_ff;
      len_new      = len_ff;
      mm_count_new = mm_count_ff + LEN_W'(mm_now);

      unique case (state_ff)
         ST_LOAD: begin
            if (req_chan.valid) begin
               if (len_ff == '0) strand_in = req_chan.strand;
               if (len_ff < LEN_W'(MAX_LEN)) len_new = len_ff + LEN_W'(1);
               len_in = len_new;
               if (req_chan.last_base) begin
                  // short or other-strand sequences end here
                  if (len_new < LEN_W'(2) ||
                      (strand_in != STRAND_FWD && strand_in != STRAND_REV)) begin
                     len_in = '0;
                  end else begin
                     idx_in      = '0;
                     prev_mm_in  = 1'b0;
                     mm_count_in = '0;
                     state_in    = ST_CHK_RD;
                  end
               end
            end
         end
         ST_CHK_RD: begin
            state_in = ST_CHK_EV;
         end
         ST_CHK_EV: begin
            if (mm_now && prev_mm_ff) begin
               // adjacent mismatches: indel signature, report nothing
               len_in   = '0;
               state_in = ST_LOAD;
            end else if (at_end) begin
               if (mm_count_new == '0) begin
                  len_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  limit_in    = (mm_count_new > LEN_W'(RESULT_CAP)) ? CAP_W'(RESULT_CAP)
                                                                    : CAP_W'(mm_count_new);
                  emit_cnt_in = '0;
                  idx_in      = '0;
                  state_in    = ST_EM_RD;
               end
            end else begin
               prev_mm_in  = mm_now;
               mm_count_in = mm_count_new;
               idx_in      = idx_ff + ADDR_W'(1);
               state_in    = ST_CHK_RD;
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_EV;
         end
         ST_EM_EV: begin
            if (mm_now) begin
               pos_in       = POS_W'(idx_ff);
               normal_in    = h_rd_data;
               mutant_in    = mutant_now;
               last_in      = (emit_cnt_ff == limit_ff - CAP_W'(1));
               rsp_valid_in = 1'b1;
               state_in     = ST_EM_OUT;
            end else if (at_end) begin
               len_in   = '0;
               state_in = ST_LOAD;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_EM_RD;
            end
         end
         ST_EM_OUT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               emit_cnt_in  = emit_cnt_ff + CAP_W'(1);
               if (last_ff || at_end) begin
                  len_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.snv_position = pos_ff;
   assign rsp_chan.normal_base  = normal_ff;
   assign rsp_chan.mutant_base  = mutant_ff;
   assign rsp_chan.last_snv     = last_ff;

   // final response of a sequence taken this cycle
   assign last_taken = rsp_valid_ff && rsp_chan.ready && last_ff;

   // Checks
   `IMC_ASSERT_NOW(a_rsp_only_in_emit, clock, reset, rsp_valid_ff, state_ff == ST_EM_OUT)
   `IMC_ASSERT_NOW(a_len_bounded, clock, reset, 1'b1, len_ff <= LEN_W'(MAX_LEN))
   `IMC_ASSERT_NOW(a_scan_len_ok, clock, reset, state_ff != ST_LOAD, len_ff >= LEN_W'(2))
   `IMC_ASSERT_NOW(a_emit_under_cap, clock, reset, state_ff == ST_EM_OUT, emit_cnt_ff < limit_ff)
   `IMC_ASSERT_NEXT(a_last_ends_seq, clock, reset, last_taken, state_ff == ST_LOAD && len_ff == '0)

endmodule
